### sv/oep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_pkg
// Shared widths, types and helpers for the octagonal envelope block.
// ----------------------------------------------------------------------------
package oep_pkg;

  localparam int CoordW    = 24;
  localparam int ExtW      = CoordW + 1;
  localparam int NumVtx    = 8;
  localparam int VtxIdxW   = 3;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = 1;
  localparam int FifoCntW  = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ExtW-1:0]   ext_val_t;

  // running extremes of one set
  typedef struct packed {
    coord_t   min_x;
    coord_t   max_x;
    coord_t   min_y;
    coord_t   max_y;
    ext_val_t min_sum;
    ext_val_t max_sum;
    ext_val_t min_diff;
    ext_val_t max_diff;
  } ext_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  function automatic ext_val_t widen(coord_t v);
    return {v[CoordW-1], v};
  endfunction

endpackage

### sv/oep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_if
// Valid/ready channels for points in and envelope vertices out.
// ----------------------------------------------------------------------------
interface oep_point_if import oep_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   set_end;

  modport source (output valid, output point_x, output point_y, output set_end,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input set_end,
                  output ready);
endinterface

interface oep_vertex_if import oep_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   final_vertex;

  modport source (output valid, output vertex_x, output vertex_y,
                  output final_vertex, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y,
                  input final_vertex, output ready);
endinterface

### sv/oep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_front
// Takes one point per cycle while the queue has room and folds it into the
// running extremes; on a set's last point it queues the finished extremes.
// ----------------------------------------------------------------------------
module oep_front import oep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  oep_point_if.sink   point_i,
  output logic        push_o,
  output ext_t        push_ext_o,
  input  logic        push_ready_i
);

  logic     have_point_q, have_point_d;
  ext_t     ext_q, ext_d;
  logic     accept;
  ext_val_t pt_sum, pt_diff;

  assign point_i.ready = push_ready_i;
  assign accept        = point_i.valid && push_ready_i;

  always_comb begin
    pt_sum  = widen(point_i.point_x) + widen(point_i.point_y);
    pt_diff = widen(point_i.point_x) - widen(point_i.point_y);
    if (!have_point_q) begin
      // first point of a set seeds every extreme
      ext_d.min_x    = point_i.point_x;
      ext_d.max_x    = point_i.point_x;
      ext_d.min_y    = point_i.point_y;
      ext_d.max_y    = point_i.point_y;
      ext_d.min_sum  = pt_sum;
      ext_d.max_sum  = pt_sum;
      ext_d.min_diff = pt_diff;
      ext_d.max_diff = pt_diff;
    end else begin
      ext_d.min_x = ($signed(point_i.point_x) < $signed(ext_q.min_x)) ?
                    point_i.point_x : ext_q.min_x;
      ext_d.max_x = ($signed(point_i.point_x) > $signed(ext_q.max_x)) ?
                    point_i.point_x : ext_q.max_x;
      ext_d.min_y = ($signed(point_i.point_y) < $signed(ext_q.min_y)) ?
                    point_i.point_y : ext_q.min_y;
      ext_d.max_y = ($signed(point_i.point_y) > $signed(ext_q.max_y)) ?
                    point_i.point_y : ext_q.max_y;
      ext_d.min_sum  = ($signed(pt_sum) < $signed(ext_q.min_sum)) ?
                       pt_sum : ext_q.min_sum;
      ext_d.max_sum  = ($signed(pt_sum) > $signed(ext_q.max_sum)) ?
                       pt_sum : ext_q.max_sum;
      ext_d.min_diff = ($signed(pt_diff) < $signed(ext_q.min_diff)) ?
                       pt_diff : ext_q.min_diff;
      ext_d.max_diff = ($signed(pt_diff) > $signed(ext_q.max_diff)) ?
                       pt_diff : ext_q.max_diff;
    end
    have_point_d = accept ? !point_i.set_end : have_point_q;
  end

  assign push_o     = accept && point_i.set_end;
  assign push_ext_o = ext_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_point_q <= 1'b0;
    end else begin
      have_point_q <= have_point_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ext_q <= ext_d;
    end
  end

endmodule

### sv/oep_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_fifo
// Short queue of finished set extremes between the front and the back.
// ----------------------------------------------------------------------------
module oep_fifo import oep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ext_t push_ext_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output ext_t pop_ext_o,
  input  logic pop_i
);

  ext_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_ext_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_ext_i;
    end
  end

endmodule

### sv/oep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_back
// Turns a set's extremes into the eight octagon corners, drops repeats and
// streams the kept corners one per ready cycle through an output register.
// ----------------------------------------------------------------------------
module oep_back import oep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  ext_t        pop_ext_i,
  output logic        pop_o,
  oep_vertex_if.source vertex_o
);

  // corner stage
  logic                sta_valid_q;
  vertex_t             sta_vtx_q [NumVtx];
  vertex_t             corner    [NumVtx];
  // emitter
  logic [NumVtx-1:0]   em_mask_q, em_mask_d;
  vertex_t             em_vtx_q  [NumVtx];
  logic [NumVtx-1:0]   keep;
  logic [NumVtx-1:0]   pick_oh, mask_rest, mask_after;
  logic [VtxIdxW-1:0]  pick_idx;
  logic                out_free, emit, em_load;
  // output register
  logic                out_valid_q;
  vertex_t             out_vtx_q;
  logic                out_final_q;

  // all corners lie inside the bounding box, so the low bits are exact
  always_comb begin
    corner[0].x = coord_t'(pop_ext_i.min_diff + widen(pop_ext_i.max_y));
    corner[0].y = pop_ext_i.max_y;
    corner[1].x = pop_ext_i.min_x;
    corner[1].y = coord_t'(widen(pop_ext_i.min_x) - pop_ext_i.min_diff);
    corner[2].x = pop_ext_i.min_x;
    corner[2].y = coord_t'(pop_ext_i.min_sum - widen(pop_ext_i.min_x));
    corner[3].x = coord_t'(pop_ext_i.min_sum - widen(pop_ext_i.min_y));
    corner[3].y = pop_ext_i.min_y;
    corner[4].x = coord_t'(pop_ext_i.max_diff + widen(pop_ext_i.min_y));
    corner[4].y = pop_ext_i.min_y;
    corner[5].x = pop_ext_i.max_x;
    corner[5].y = coord_t'(widen(pop_ext_i.max_x) - pop_ext_i.max_diff);
    corner[6].x = pop_ext_i.max_x;
    corner[6].y = coord_t'(pop_ext_i.max_sum - widen(pop_ext_i.max_x));
    corner[7].x = coord_t'(pop_ext_i.max_sum - widen(pop_ext_i.max_y));
    corner[7].y = pop_ext_i.max_y;
  end

  // a corner is kept unless it repeats its predecessor; the last one also
  // goes if it closes onto the first
  always_comb begin
    keep[0] = 1'b1;
    for (int i = 1; i < NumVtx; i++) begin
      keep[i] = (sta_vtx_q[i] != sta_vtx_q[i-1]);
    end
    keep[NumVtx-1] = keep[NumVtx-1] && (sta_vtx_q[NumVtx-1] != sta_vtx_q[0]);
  end

  always_comb begin
    pick_oh  = em_mask_q & (~em_mask_q + 1'b1);
    pick_idx = '0;
    for (int i = 0; i < NumVtx; i++) begin
      if (pick_oh[i]) begin
        pick_idx = VtxIdxW'(i);
      end
    end
    mask_rest  = em_mask_q & ~pick_oh;
    out_free   = !out_valid_q || vertex_o.ready;
    emit       = out_free && (em_mask_q != '0);
    mask_after = emit ? mask_rest : em_mask_q;
    em_load    = sta_valid_q && (mask_after == '0);
    em_mask_d  = em_load ? keep : mask_after;
    pop_o      = pop_valid_i && (!sta_valid_q || em_load);
  end

  assign vertex_o.valid        = out_valid_q;
  assign vertex_o.vertex_x     = out_vtx_q.x;
  assign vertex_o.vertex_y     = out_vtx_q.y;
  assign vertex_o.final_vertex = out_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sta_valid_q <= 1'b0;
      em_mask_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      em_mask_q <= em_mask_d;
      if (pop_o) begin
        sta_valid_q <= 1'b1;
      end else if (em_load) begin
        sta_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (vertex_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sta_vtx_q <= corner;
    end
    if (em_load) begin
      em_vtx_q <= sta_vtx_q;
    end
    if (emit) begin
      out_vtx_q   <= em_vtx_q[pick_idx];
      out_final_q <= (mask_rest == '0);
    end
  end

endmodule

### sv/octagonal_envelope_of_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octagonal_envelope_of_points
// Streams the eight-direction bounding octagon of each point set.
// ----------------------------------------------------------------------------
// Points are taken at one per cycle; the front folds each into the running
// min/max of x, y, x+y and x-y. The point that closes a set hands its
// extremes to a two-entry queue, so the next set starts at once. The back
// drains the queue: the corner stage registers the corners, repeats are marked
// as they enter the emitter, then one kept vertex per cycle (1 to 8 per set)
// leaves through the output register while the output is taken, top-left first,
// counter-clockwise, with the last one flagged final. Point intake stalls only
// when sets end faster than their vertices are taken and the queue is full.
module octagonal_envelope_of_points import oep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  oep_point_if.sink    point_i,
  oep_vertex_if.source vertex_o
);

  logic push, push_ready, pop_valid, pop;
  ext_t push_ext, pop_ext;

  oep_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_i      (point_i),
    .push_o       (push),
    .push_ext_o   (push_ext),
    .push_ready_i (push_ready)
  );

  oep_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ext_i   (push_ext),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ext_o    (pop_ext),
    .pop_i        (pop)
  );

  oep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ext_i   (pop_ext),
    .pop_o       (pop),
    .vertex_o    (vertex_o)
  );

endmodule

### sv/oep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oep_checker
// Port-level checks on the octagonal envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module oep_checker import oep_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_i,
  input logic   in_set_end_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input coord_t out_x_i,
  input coord_t out_y_i,
  input logic   out_final_i
);

  // queue, corner stage, emitter and output register
  localparam int MaxPending = FifoDepth + 3;

  logic [3:0] pend_q;
  logic       set_in, set_out, out_xfer;

  assign set_in   = in_valid_i && in_ready_i && in_set_end_i;
  assign out_xfer = out_valid_i && out_ready_i;
  assign set_out  = out_xfer && out_final_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (set_in && !set_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (set_out && !set_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("vertex valid dropped before transfer");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("vertex shown with no closed set outstanding");

  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(MaxPending))
    else $error("more sets in flight than the datapath holds");

  a_no_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && $past(out_xfer && !out_final_i) |->
      (out_x_i != $past(out_x_i)) || (out_y_i != $past(out_y_i)))
    else $error("consecutive vertices of a set are equal");

endmodule

bind octagonal_envelope_of_points oep_checker u_oep_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (point_i.valid),
  .in_ready_i   (point_i.ready),
  .in_set_end_i (point_i.set_end),
  .out_valid_i  (vertex_o.valid),
  .out_ready_i  (vertex_o.ready),
  .out_x_i      (vertex_o.vertex_x),
  .out_y_i      (vertex_o.vertex_y),
  .out_final_i  (vertex_o.final_vertex)
);
